// ----- rtl/core/range_scan_to_grid_cell_assert.svh -----
// assertion macros for the range scan block
`ifndef RANGE_SCAN_TO_GRID_CELL_ASSERT_SVH
`define RANGE_SCAN_TO_GRID_CELL_ASSERT_SVH

`ifndef SYNTHESIS
`define RSGC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("range scan assertion failed");
`define RSGC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("range scan assertion failed");
`else
`define RSGC_ASSERT_SAME(lbl, ante, cons)
`define RSGC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/rsgc_pkg.sv -----
package rsgc_pkg;

   localparam logic [2:0] CSR_CELL_SIZE_X = 3'd0;
   localparam logic [2:0] CSR_CELL_SIZE_Y = 3'd1;
   localparam logic [2:0] CSR_GRID_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_GRID_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_RANGE_LIMIT = 3'd4;

   localparam int QUOT_BITS = 24;

   typedef struct packed {
      logic        neg;
      logic [16:0] mag;
   } trig_type;

   localparam logic [16:0] QSINE [0:90] = '{
      17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
      17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
      17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
      17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
      17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
      17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
      17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
      17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
      17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
      17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
      17'd61965, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
      17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
      17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
   };

   // signed sine of a whole-degree angle 0..359, q1.16 magnitude
   function automatic trig_type sine_deg(input logic [8:0] a);
      trig_type   t;
      logic [6:0] idx;
      if (a <= 9'd90) begin
         idx = a[6:0];
         t.neg = 1'b0;
      end else if (a <= 9'd180) begin
         idx = 7'(9'd180 - a);
         t.neg = 1'b0;
      end else if (a <= 9'd270) begin
         idx = 7'(a - 9'd180);
         t.neg = 1'b1;
      end else begin
         idx = 7'(9'd360 - a);
         t.neg = 1'b1;
      end
      t.mag = QSINE[idx];
      return t;
   endfunction

endpackage

// ----- rtl/core/range_scan_to_grid_cell.sv -----
// an item goes through the angle, lookup, product, hit-point, divider and output registers to rsp_valid
// throughput: one item per clock; busy stays low, start may be high every cycle
// the cell divide is a 24-stage restoring divider, one quotient bit per stage
// the receiver cannot stall, so every result is shown for exactly one cycle
// synchronous reset clears the pipeline valid bits and loads the register defaults
`include "range_scan_to_grid_cell_assert.svh"
module range_scan_to_grid_cell #(
   parameter int GRID_MAX = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_robot_x,
   input  logic signed [23:0] req_robot_y,
   input  logic [8:0]         req_robot_heading,
   input  logic [8:0]         req_beam_angle,
   input  logic [15:0]        req_beam_range,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_cell_x,
   output logic signed [15:0] rsp_cell_y,
   output logic               rsp_mark_obstacle,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int QB = rsgc_pkg::QUOT_BITS;

   logic [15:0] cell_size_x_ff, cell_size_y_ff, range_limit_ff;
   logic [10:0] grid_width_ff, grid_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_x_ff <= 16'd256;
         cell_size_y_ff <= 16'd256;
         grid_width_ff  <= 11'd64;
         grid_height_ff <= 11'd64;
         range_limit_ff <= 16'd640;
      end else if (csr_we) begin
         case (csr_index)
            rsgc_pkg::CSR_CELL_SIZE_X: cell_size_x_ff <= csr_wdata;
            rsgc_pkg::CSR_CELL_SIZE_Y: cell_size_y_ff <= csr_wdata;
            rsgc_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[10:0];
            rsgc_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[10:0];
            rsgc_pkg::CSR_RANGE_LIMIT: range_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0] div_x, div_y, gw_lim, gh_lim;
   assign div_x  = (cell_size_x_ff == 16'd0) ? 16'd1 : cell_size_x_ff;
   assign div_y  = (cell_size_y_ff == 16'd0) ? 16'd1 : cell_size_y_ff;
   assign gw_lim = (32'(grid_width_ff) > GRID_MAX) ? 16'(GRID_MAX) : 16'(grid_width_ff);
   assign gh_lim = (32'(grid_height_ff) > GRID_MAX) ? 16'(GRID_MAX) : 16'(grid_height_ff);

   assign busy = 1'b0;

   // stage 1: angle sum mod 360 for sine and for cosine
   logic        v1_ff, lt1_ff;
   logic [8:0]  ang1_ff, cang1_ff, ang1_in, cang1_in;
   logic [23:0] rx1_ff, ry1_ff;
   logic [15:0] rng1_ff;
   logic [9:0]  sum, csum;

   always_comb begin
      sum = 10'(req_robot_heading) + 10'(req_beam_angle);
      // the sum of two 9-bit angles can pass 720
      if (sum >= 10'd720)      ang1_in = 9'(sum - 10'd720);
      else if (sum >= 10'd360) ang1_in = 9'(sum - 10'd360);
      else                     ang1_in = 9'(sum);
      csum = 10'(ang1_in) + 10'd90;
      cang1_in = (csum >= 10'd360) ? 9'(csum - 10'd360) : 9'(csum);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start && !busy;
      ang1_ff  <= ang1_in;
      cang1_ff <= cang1_in;
      rx1_ff   <= req_robot_x;
      ry1_ff   <= req_robot_y;
      rng1_ff  <= req_beam_range;
      lt1_ff   <= req_beam_range < range_limit_ff;
   end

   // stage 2: quarter-wave lookup
   logic                v2_ff, lt2_ff;
   rsgc_pkg::trig_type  sn2_ff, cs2_ff;
   logic [23:0]         rx2_ff, ry2_ff;
   logic [15:0]         rng2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      sn2_ff  <= rsgc_pkg::sine_deg(ang1_ff);
      cs2_ff  <= rsgc_pkg::sine_deg(cang1_ff);
      rx2_ff  <= rx1_ff;
      ry2_ff  <= ry1_ff;
      rng2_ff <= rng1_ff;
      lt2_ff  <= lt1_ff;
   end

   // stage 3: range times cos and sin
   logic        v3_ff, lt3_ff, nx3_ff, ny3_ff;
   logic [32:0] px3_ff, py3_ff;
   logic [23:0] rx3_ff, ry3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      px3_ff <= 33'(rng2_ff) * 33'(cs2_ff.mag);
      py3_ff <= 33'(rng2_ff) * 33'(sn2_ff.mag);
      nx3_ff <= cs2_ff.neg;
      ny3_ff <= sn2_ff.neg;
      rx3_ff <= rx2_ff;
      ry3_ff <= ry2_ff;
      lt3_ff <= lt2_ff;
   end

   // stage 4: hit point, drop the 16 trig fraction bits, fold negatives for floor
   logic [41:0] hx, hy, bx, by;
   logic [24:0] nx, ny;

   always_comb begin
      bx = {{2{rx3_ff[23]}}, rx3_ff, 16'd0};
      by = {{2{ry3_ff[23]}}, ry3_ff, 16'd0};
      hx = nx3_ff ? bx - 42'(px3_ff) : bx + 42'(px3_ff);
      hy = ny3_ff ? by - 42'(py3_ff) : by + 42'(py3_ff);
      nx = hx[40:16];
      ny = hy[40:16];
   end

   // divider pipe, index 0 is the stage 4 register
   logic          dv_ff   [0:QB];
   logic          lt_ff   [0:QB];
   logic          sgx_ff  [0:QB];
   logic          sgy_ff  [0:QB];
   logic [15:0]   remx_ff [0:QB];
   logic [15:0]   remy_ff [0:QB];
   logic [QB-1:0] wx_ff   [0:QB];
   logic [QB-1:0] wy_ff   [0:QB];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= v3_ff;
      lt_ff[0]   <= lt3_ff;
      sgx_ff[0]  <= nx[24];
      sgy_ff[0]  <= ny[24];
      remx_ff[0] <= 16'd0;
      remy_ff[0] <= 16'd0;
      // floor(n/d) = ~((-n-1)/d) for negative n
      wx_ff[0]   <= nx[QB-1:0] ^ {QB{nx[24]}};
      wy_ff[0]   <= ny[QB-1:0] ^ {QB{ny[24]}};
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [16:0] tx, ty;
      logic        qx, qy;
      logic [15:0] rx_in, ry_in;

      always_comb begin
         tx = {remx_ff[k], wx_ff[k][QB-1]};
         ty = {remy_ff[k], wy_ff[k][QB-1]};
         qx = tx >= {1'b0, div_x};
         qy = ty >= {1'b0, div_y};
         rx_in = qx ? 16'(tx - {1'b0, div_x}) : tx[15:0];
         ry_in = qy ? 16'(ty - {1'b0, div_y}) : ty[15:0];
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else       dv_ff[k+1] <= dv_ff[k];
         lt_ff[k+1]   <= lt_ff[k];
         sgx_ff[k+1]  <= sgx_ff[k];
         sgy_ff[k+1]  <= sgy_ff[k];
         remx_ff[k+1] <= rx_in;
         remy_ff[k+1] <= ry_in;
         wx_ff[k+1]   <= {wx_ff[k][QB-2:0], qx};
         wy_ff[k+1]   <= {wy_ff[k][QB-2:0], qy};
      end
   end

   // output stage: saturate, inside test
   logic [15:0] cx_in, cy_in;
   logic        big_x, big_y, mark_in;
   logic        rsp_valid_ff, mark_ff;
   logic [15:0] cx_ff, cy_ff;

   always_comb begin
      big_x = |wx_ff[QB][QB-1:15];
      big_y = |wy_ff[QB][QB-1:15];
      if (sgx_ff[QB]) cx_in = big_x ? 16'h8000 : ~wx_ff[QB][15:0];
      else            cx_in = big_x ? 16'h7fff : wx_ff[QB][15:0];
      if (sgy_ff[QB]) cy_in = big_y ? 16'h8000 : ~wy_ff[QB][15:0];
      else            cy_in = big_y ? 16'h7fff : wy_ff[QB][15:0];
      mark_in = dv_ff[QB] && lt_ff[QB] && !cx_in[15] && !cy_in[15] &&
                (cx_in < gw_lim) && (cy_in < gh_lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mark_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ff[QB];
         mark_ff      <= mark_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mark_obstacle = mark_ff;
   assign rsp_cell_x        = cx_ff;
   assign rsp_cell_y        = cy_ff;

   `RSGC_ASSERT_NEXT(a_tail_to_rsp, dv_ff[QB], rsp_valid)
   `RSGC_ASSERT_SAME(a_mark_inside, mark_ff, rsp_valid_ff && !cx_ff[15] && !cy_ff[15])
   for (genvar j = 1; j <= QB; j++) begin : g_chk
      `RSGC_ASSERT_SAME(a_rem_below_div, dv_ff[j], remx_ff[j] < div_x && remy_ff[j] < div_y)
   end

endmodule

// ----- dv/tb_range_scan_to_grid_cell.sv -----
`timescale 1ns / 100ps
module tb_range_scan_to_grid_cell;

   localparam logic [2:0] CSR_UNMAPPED = 3'd6;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 3000;
   localparam int MAP_GRID_MAX = 1024;

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [8:0]         heading;
      logic [8:0]         angle;
      logic [15:0]        range;
   } reading_type;

   typedef struct {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic               mark;
   } cell_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [23:0] req_robot_x = '0;
   logic signed [23:0] req_robot_y = '0;
   logic [8:0]  req_robot_heading = '0;
   logic [8:0]  req_beam_angle = '0;
   logic [15:0] req_beam_range = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_cell_x;
   logic signed [15:0] rsp_cell_y;
   logic rsp_mark_obstacle;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   reading_type pending_readings[$];
   cell_type    expected_cells[$];
   logic     took = 1'b0;
   logic     failed = 1'b0;
   int       idle_pct = 34;
   int       readings_queued = 0;
   int       readings_taken = 0;
   int       stall_cycles = 0;

   // shadow copy of the map registers
   logic [15:0] cell_w = 16'd256;
   logic [15:0] cell_h = 16'd256;
   logic [10:0] grid_w = 11'd64;
   logic [10:0] grid_h = 11'd64;
   logic [15:0] near_limit = 16'd640;

   range_scan_to_grid_cell dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint signed_sine(int deg);
      if (deg <= 90) return longint'(rsgc_pkg::QSINE[deg]);
      if (deg <= 180) return longint'(rsgc_pkg::QSINE[180 - deg]);
      if (deg <= 270) return -longint'(rsgc_pkg::QSINE[deg - 180]);
      return -longint'(rsgc_pkg::QSINE[360 - deg]);
   endfunction

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic cell_type locate_cell(reading_type r);
      cell_type c;
      int     deg;
      longint hx, hy, dx, dy, qx, qy, gw, gh;
      deg = int'(r.heading) + int'(r.angle);
      while (deg >= 360) deg = deg - 360;
      hx = longint'(r.x) * 65536 + longint'(r.range) * signed_sine((deg + 90) % 360);
      hy = longint'(r.y) * 65536 + longint'(r.range) * signed_sine(deg);
      dx = longint'(cell_w == 0 ? 16'd1 : cell_w) * 65536;
      dy = longint'(cell_h == 0 ? 16'd1 : cell_h) * 65536;
      qx = clip16(floor_quot(hx, dx));
      qy = clip16(floor_quot(hy, dy));
      gw = grid_w > MAP_GRID_MAX ? MAP_GRID_MAX : grid_w;
      gh = grid_h > MAP_GRID_MAX ? MAP_GRID_MAX : grid_h;
      c.cx = qx[15:0];
      c.cy = qy[15:0];
      c.mark = (r.range < near_limit) && qx >= 0 && qy >= 0 && qx < gw && qy < gh;
      return c;
   endfunction

   // driver: hold an item until taken, then maybe idle
   always @(negedge clock) begin
      reading_type r;
      if (!reset && (!start || took)) begin
         if (pending_readings.size() > 0 && $urandom_range(99) >= idle_pct) begin
            r = pending_readings.pop_front();
            start <= 1'b1;
            req_robot_x <= r.x;
            req_robot_y <= r.y;
            req_robot_heading <= r.heading;
            req_beam_angle <= r.angle;
            req_beam_range <= r.range;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      reading_type r;
      cell_type    e;
      if (!reset) begin
         took <= start && !busy;
         if (start && !busy) begin
            r.x = req_robot_x;
            r.y = req_robot_y;
            r.heading = req_robot_heading;
            r.angle = req_beam_angle;
            r.range = req_beam_range;
            expected_cells.insert(expected_cells.size(), locate_cell(r));
            readings_taken++;
         end
         if (rsp_valid) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected result cx=%0d cy=%0d mark=%0b", $time,
                        rsp_cell_x, rsp_cell_y, rsp_mark_obstacle);
               failed = 1'b1;
            end else begin
               e = expected_cells.pop_front();
               if (rsp_cell_x !== e.cx || rsp_cell_y !== e.cy ||
                   rsp_mark_obstacle !== e.mark) begin
                  $display("%0t: mismatch exp cx=%0d cy=%0d mark=%0b act cx=%0d cy=%0d mark=%0b",
                           $time, e.cx, e.cy, e.mark, rsp_cell_x, rsp_cell_y,
                           rsp_mark_obstacle);
                  failed = 1'b1;
               end
            end
         end
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles > STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic add_reading(int x, int y, int hd, int ang, int rng);
      reading_type r;
      r.x = x[23:0];
      r.y = y[23:0];
      r.heading = hd[8:0];
      r.angle = ang[8:0];
      r.range = rng[15:0];
      pending_readings.insert(pending_readings.size(), r);
      readings_queued++;
   endtask

   task automatic add_random_readings(int n);
      int x, y, rng;
      repeat (n) begin
         // mostly near the grid origin so hits land inside and get marked
         if ($urandom_range(99) < 60) begin
            x = $urandom_range(20000) - 2000;
            y = $urandom_range(20000) - 2000;
         end else begin
            x = $urandom;
            y = $urandom;
         end
         rng = ($urandom_range(99) < 50) ? $urandom_range(2000) : $urandom;
         add_reading(x, y, $urandom_range(511), $urandom_range(511), rng);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         rsgc_pkg::CSR_CELL_SIZE_X: cell_w = val;
         rsgc_pkg::CSR_CELL_SIZE_Y: cell_h = val;
         rsgc_pkg::CSR_GRID_WIDTH:  grid_w = val[10:0];
         rsgc_pkg::CSR_GRID_HEIGHT: grid_h = val[10:0];
         rsgc_pkg::CSR_RANGE_LIMIT: near_limit = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      wait (readings_taken == readings_queued && expected_cells.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_map(int cw, int ch, int gw, int gh, int lim);
      write_reg(rsgc_pkg::CSR_CELL_SIZE_X, cw[15:0]);
      write_reg(rsgc_pkg::CSR_CELL_SIZE_Y, ch[15:0]);
      write_reg(rsgc_pkg::CSR_GRID_WIDTH, gw[15:0]);
      write_reg(rsgc_pkg::CSR_GRID_HEIGHT, gh[15:0]);
      write_reg(rsgc_pkg::CSR_RANGE_LIMIT, lim[15:0]);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed readings under the reset map
      add_reading(0, 0, 0, 0, 0);
      add_reading(0, 0, 0, 0, 65535);
      add_reading(-8388608, -8388608, 90, 0, 100);
      add_reading(8388607, 8388607, 180, 0, 100);
      add_reading(256, 256, 270, 0, 300);
      add_reading(256, 256, 359, 0, 639);
      add_reading(256, 256, 0, 90, 640);
      add_reading(1000, 1000, 511, 511, 500);
      add_reading(1000, 1000, 300, 300, 500);
      add_reading(100, 100, 45, 0, 600);
      add_reading(100, 100, 135, 0, 600);
      add_reading(100, 100, 225, 0, 600);
      add_reading(100, 100, 315, 0, 600);
      add_reading(16383, 16383, 0, 0, 200);
      add_reading(16384, 100, 0, 0, 0);
      add_reading(-1, -1, 0, 0, 0);
      add_reading(-256, 100, 0, 0, 10);
      add_reading(100, 100, 360, 0, 256);
      add_random_readings(180);
      drain();

      // no idling in this stretch
      idle_pct = 0;
      set_map(1, 1, 1024, 1024, 65535);
      write_reg(CSR_UNMAPPED, 16'h0000);
      add_reading(8388607, -8388608, 0, 0, 65535);
      add_reading(0, 0, 0, 0, 0);
      add_random_readings(200);
      drain();
      idle_pct = 34;

      set_map(65535, 65535, 0, 0, 0);
      add_random_readings(150);
      drain();

      set_map(0, 0, 2047, 2047, 65535);
      add_random_readings(150);
      drain();

      set_map(64, 128, 200, 150, 4000);
      add_random_readings(150);
      drain();

      set_map($urandom_range(1, 65535), $urandom_range(1, 2000), $urandom_range(1, 1024),
              $urandom_range(1, 1024), $urandom);
      add_random_readings(150);
      drain();

      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
